FILE: rtl/core/tdp_pkg.sv
package tdp_pkg;

  localparam int NUMBER_BITS = 64;
  localparam int SQ_BITS     = NUMBER_BITS + 1;
  localparam int CNT_BITS    = $clog2(NUMBER_BITS);

  typedef logic [NUMBER_BITS-1:0] number_t;
  typedef logic [SQ_BITS-1:0]     square_t;
  typedef logic [CNT_BITS-1:0]    count_t;

  localparam count_t CNT_LAST = CNT_BITS'(NUMBER_BITS - 1);

  // command to the remainder unit
  typedef struct packed {
    logic start;
  } rem_cmd_t;

  // status back from the remainder unit
  typedef struct packed {
    logic busy;
    logic done;
    logic zero;
  } rem_stat_t;

  // command to the candidate generator
  typedef struct packed {
    logic init;
    logic step;
  } cand_cmd_t;

endpackage

FILE: rtl/core/tdp_rem.sv
module tdp_rem (
  input  logic              clk,
  input  logic              rst,
  input  tdp_pkg::rem_cmd_t cmd,
  input  tdp_pkg::number_t  dividend,
  input  tdp_pkg::number_t  divisor,
  output tdp_pkg::rem_stat_t stat
);
  import tdp_pkg::*;

  number_t q;
  number_t r;
  number_t r_next;
  count_t  cnt;
  logic    busy;
  logic    done;
  logic    zero;
  logic [NUMBER_BITS:0] trial;

  // one quotient bit per cycle, restoring
  always_comb begin
    trial = {r, q[NUMBER_BITS-1]};
    if (trial >= {1'b0, divisor}) begin
      r_next = NUMBER_BITS'(trial - {1'b0, divisor});
    end else begin
      r_next = trial[NUMBER_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      zero <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cmd.start && !busy) begin
        q    <= dividend;
        r    <= '0;
        cnt  <= CNT_LAST;
        busy <= 1'b1;
      end else if (busy) begin
        q   <= {q[NUMBER_BITS-2:0], 1'b0};
        r   <= r_next;
        cnt <= cnt - count_t'(1);
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
          zero <= (r_next == '0);
        end
      end
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign stat.zero = zero;

endmodule

FILE: rtl/core/tdp_cand.sv
module tdp_cand (
  input  logic               clk,
  input  tdp_pkg::cand_cmd_t cmd,
  input  tdp_pkg::number_t   n,
  output tdp_pkg::number_t   d,
  output logic               over
);
  import tdp_pkg::*;

  square_t sq;
  square_t d4;

  // d stays far below 2^62, so its top bit is always clear
  assign d4   = {d[NUMBER_BITS-2:0], 2'b00};
  assign over = (sq > {1'b0, n});

  // odd candidates only: (d+2)^2 = d^2 + 4d + 4
  always_ff @(posedge clk) begin
    if (cmd.init) begin
      d  <= NUMBER_BITS'(3);
      sq <= SQ_BITS'(9);
    end else if (cmd.step) begin
      d  <= d + NUMBER_BITS'(2);
      sq <= sq + d4 + SQ_BITS'(4);
    end
  end

endmodule

FILE: rtl/core/trial_division_prime_test_unit.sv
// negatives, 0, 1, 2 and even numbers are settled by the screen state alone
// otherwise each odd candidate divisor, 3 up to floor(sqrt(n)), is tried in turn
// by the bit-serial remainder unit; one transaction is worked on at a time
// a finished result waits in the output register while the next transaction is taken
// rst is synchronous, active high; clears control state, nothing else to clear
module trial_division_prime_test_unit (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  tdp_pkg::number_t number,
  output logic             out_valid,
  input  logic             out_stall,
  output logic             is_prime
);
  import tdp_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCREEN,
    S_CHECK,
    S_DIV,
    S_FINISH
  } state_t;

  state_t    state;
  number_t   n;
  logic      res;
  rem_cmd_t  rem_cmd;
  rem_stat_t rem_stat;
  cand_cmd_t cand_cmd;
  number_t   cand_d;
  logic      cand_over;
  logic      n_below_two;
  logic      out_load;

  // bit-serial remainder of n by the current candidate
  tdp_rem u_rem (
    .clk      (clk),
    .rst      (rst),
    .cmd      (rem_cmd),
    .dividend (n),
    .divisor  (cand_d),
    .stat     (rem_stat)
  );

  // odd candidate divisor and its running square
  tdp_cand u_cand (
    .clk  (clk),
    .cmd  (cand_cmd),
    .n    (n),
    .d    (cand_d),
    .over (cand_over)
  );

  assign n_below_two = (n[NUMBER_BITS-1:1] == '0);

  // only idle takes a new transaction
  assign in_stall = (state != S_IDLE);

  // finish loads the output register once it is free or being emptied
  assign out_load = (state == S_FINISH) && (!out_valid || !out_stall);

  always_comb begin
    rem_cmd.start = (state == S_CHECK) && !cand_over;
    cand_cmd.init = (state == S_SCREEN);
    cand_cmd.step = (state == S_DIV) && rem_stat.done && !rem_stat.zero;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
        is_prime  <= res;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            n     <= number;
            state <= S_SCREEN;
          end
        end
        S_SCREEN: begin
          // negatives, zero and one are not prime; two is; other evens are not
          priority if (n[NUMBER_BITS-1] || n_below_two) begin
            res   <= 1'b0;
            state <= S_FINISH;
          end else if (n == NUMBER_BITS'(2)) begin
            res   <= 1'b1;
            state <= S_FINISH;
          end else if (!n[0]) begin
            res   <= 1'b0;
            state <= S_FINISH;
          end else begin
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          // square past n: no divisor found
          if (cand_over) begin
            res   <= 1'b1;
            state <= S_FINISH;
          end else begin
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (rem_stat.done) begin
            if (rem_stat.zero) begin
              res   <= 1'b0;
              state <= S_FINISH;
            end else begin
              state <= S_CHECK;
            end
          end
        end
        S_FINISH: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // remainder unit is never restarted mid-division
  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    rem_cmd.start |-> !rem_stat.busy)
    else $error("remainder start while busy");

  // candidates tried by division are odd and at least three
  a_odd_divisor: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |-> (cand_d[0] && (cand_d >= NUMBER_BITS'(3))))
    else $error("bad divisor in division");

  // a result appears only out of the finish state
  a_out_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == S_FINISH))
    else $error("result without finish");

  // division completes only while the sequencer waits for it
  a_done_in_div: assert property (@(posedge clk) disable iff (rst)
    rem_stat.done |-> (state == S_DIV))
    else $error("remainder done outside division");

endmodule

FILE: verif/testbench.sv
module testbench;
  import tdp_pkg::*;

  // sizes of the run
  localparam int RANDOM_ITEMS   = 70;
  localparam int QUIET_ITEMS    = 20;    // tail of the random part with no idling
  localparam int HOLD_ITEMS     = 8;     // items offered while the receiver holds off
  localparam int HOLD_CYCLES    = 300;
  localparam int SETTLE_CYCLES  = 10;    // well past the short screen-only path
  localparam int DRAIN_LIMIT    = 400000;
  localparam int SMALL_MAX      = 16383; // keeps trial division short for primes

  // one row of the directed table; has_answer marks rows whose answer is obvious
  typedef struct {
    number_t value;
    bit      has_answer;
    bit      answer;
  } directed_row_t;

  // what the block owes us for one accepted transaction
  typedef struct {
    number_t value;
    bit      prime;
  } prime_answer_t;

  logic    clk       = 1'b0;
  logic    rst       = 1'b1;
  logic    in_valid  = 1'b0;
  logic    in_stall;
  number_t number    = '0;
  logic    out_valid;
  logic    out_stall = 1'b0;
  logic    is_prime;

  prime_answer_t answers_due[$];
  int            mismatch_count = 0;
  int            results_seen   = 0;
  int            primes_seen    = 0;
  int            items_sent     = 0;
  bit            hold_request   = 1'b0;
  bit            quiet          = 1'b0;

  trial_division_prime_test_unit DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .number    (number),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .is_prime  (is_prime)
  );

  // 20-unit clock period
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // hard stop well beyond the slowest legal run
  initial begin
    #60000000;
    $display("Test completed with failures");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // primality predictor: deterministic witness test, exact below 2^64
  // ---------------------------------------------------------------------------

  // (a * b) mod m at full product width, no wrap
  function automatic logic [63:0] mul_mod(logic [63:0] a, logic [63:0] b, logic [63:0] m);
    logic [127:0] product;
    product = {64'd0, a} * {64'd0, b};
    return 64'(product % {64'd0, m});
  endfunction

  function automatic logic [63:0] pow_mod(logic [63:0] base, logic [63:0] e, logic [63:0] m);
    logic [63:0] acc;
    acc  = 64'd1 % m;
    base = base % m;
    while (e != 0) begin
      if (e[0]) acc = mul_mod(acc, base, m);
      base = mul_mod(base, base, m);
      e    = e >> 1;
    end
    return acc;
  endfunction

  function automatic bit prime_of(number_t v);
    logic [63:0] witnesses [12] = '{64'd2, 64'd3, 64'd5, 64'd7, 64'd11, 64'd13,
                                    64'd17, 64'd19, 64'd23, 64'd29, 64'd31, 64'd37};
    logic [63:0] u;
    logic [63:0] odd_part;
    logic [63:0] x;
    int          twos;
    bit          survived;
    // negatives are never prime
    if (v[NUMBER_BITS-1]) return 1'b0;
    u = 64'(v);
    if (u < 2) return 1'b0;
    // small witnesses double as a quick sieve
    foreach (witnesses[i]) begin
      if (u == witnesses[i]) return 1'b1;
      if (u % witnesses[i] == 0) return 1'b0;
    end
    // split u-1 into odd_part * 2^twos
    odd_part = u - 1;
    twos     = 0;
    while (!odd_part[0]) begin
      odd_part = odd_part >> 1;
      twos++;
    end
    foreach (witnesses[i]) begin
      x        = pow_mod(witnesses[i], odd_part, u);
      survived = (x == 1) || (x == u - 1);
      for (int k = 1; k < twos && !survived; k++) begin
        x        = mul_mod(x, x, u);
        survived = (x == u - 1);
      end
      if (!survived) return 1'b0;
    end
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // random numbers: mostly small, plus negatives and large values that have
  // a small factor so the block finishes them quickly
  // ---------------------------------------------------------------------------
  function automatic number_t random_number();
    logic [63:0] factors [5] = '{64'd3, 64'd5, 64'd7, 64'd11, 64'd13};
    logic [63:0] wide;
    int          pick;
    pick = $urandom_range(0, 99);
    wide = {$urandom, $urandom};
    if (pick < 70) return number_t'($urandom_range(0, SMALL_MAX));
    if (pick < 80) return {1'b1, wide[62:0]};            // negative
    if (pick < 88) return {1'b0, wide[62:1], 1'b0};      // large even
    // large multiple of a small prime, kept below 2^63
    return (wide >> 5) * factors[$urandom_range(0, 4)];
  endfunction

  // mismatch reporting: one line per problem, counted
  task automatic report_mismatch(input string what);
    $display("MISMATCH: %s", what);
    mismatch_count++;
  endtask

  // offer one transaction and hold it until the block takes it
  task automatic offer_number(input number_t v, input bit has_answer, input bit answer);
    prime_answer_t entry;
    in_valid <= 1'b1;
    number   <= v;
    do @(posedge clk); while (in_stall);
    entry.value = v;
    entry.prime = has_answer ? answer : prime_of(v);
    if (has_answer && answer != prime_of(v))
      report_mismatch($sformatf("table answer %0b disagrees with predictor for %0d",
                                answer, $signed(v)));
    answers_due.push_back(entry);
    items_sent++;
  endtask

  // random gap on the input side, skipped once the quiet tail starts
  task automatic maybe_idle_input();
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
  endtask

  // ---------------------------------------------------------------------------
  // receiver: random stall bursts, and one long hold-off on request
  // ---------------------------------------------------------------------------
  initial begin
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        out_stall <= 1'b1;
        for (int n = 0; n < HOLD_CYCLES; n++) @(posedge clk);
        out_stall <= 1'b0;
      end else if (!quiet && !rst && $urandom_range(0, 9) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 7)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // result checker: every accepted result against the oldest expectation
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    prime_answer_t want;
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      if (answers_due.size() == 0) begin
        report_mismatch($sformatf("result is_prime=%0b with no transaction outstanding",
                                  is_prime));
      end else begin
        want = answers_due.pop_front();
        if (is_prime)
          primes_seen++;
        if (is_prime !== want.prime)
          report_mismatch($sformatf("number %0d: is_prime=%0b, expected %0b",
                                    $signed(want.value), is_prime, want.prime));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  initial begin
    directed_row_t directed [] = '{
      '{64'd0,                   1'b1, 1'b0},  // zero
      '{64'd1,                   1'b1, 1'b0},  // one
      '{64'd2,                   1'b1, 1'b1},  // smallest prime, no trial at all
      '{64'd3,                   1'b0, 1'b0},
      '{64'd4,                   1'b1, 1'b0},
      '{64'd5,                   1'b0, 1'b0},
      '{64'd9,                   1'b0, 1'b0},  // square of a prime, d*d == n
      '{64'd25,                  1'b0, 1'b0},
      '{64'd49,                  1'b0, 1'b0},
      '{64'd37,                  1'b0, 1'b0},
      '{64'd41,                  1'b0, 1'b0},
      '{64'd1369,                1'b0, 1'b0},  // 37 squared
      '{64'd10403,               1'b0, 1'b0},  // 101 * 103, twin factors
      '{64'd63001,               1'b0, 1'b0},  // 251 squared
      '{64'd65521,               1'b0, 1'b0},  // largest 16-bit prime, long loop
      '{64'h7FFF_FFFF_FFFF_FFFF, 1'b0, 1'b0},  // largest positive, factor 7
      '{64'h7FFF_FFFF_FFFF_FFFE, 1'b1, 1'b0},  // largest even
      '{64'h4000_0000_0000_0001, 1'b0, 1'b0},  // 2^62+1, factor 5
      '{64'h5555_5555_5555_5555, 1'b0, 1'b0},
      '{64'h8000_0000_0000_0000, 1'b1, 1'b0},  // most negative
      '{64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b0},  // minus one
      '{64'hFFFF_FFFF_FFFF_FFFE, 1'b1, 1'b0}   // minus two
    };
    int n;

    // reset held from the start, then released once
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed table
    foreach (directed[i]) begin
      maybe_idle_input();
      offer_number(directed[i].value, directed[i].has_answer, directed[i].answer);
    end

    // back-pressure: receiver holds off while we keep offering, so the output
    // register fills, the next transaction stalls in the block and in_stall rises
    hold_request = 1'b1;
    for (int i = 0; i < HOLD_ITEMS; i++)
      offer_number(number_t'($urandom_range(0, 255)), 1'b0, 1'b0);
    in_valid <= 1'b0;

    // sender pause until every outstanding result is back
    while (answers_due.size() != 0) @(posedge clk);

    // random part; the last stretch runs with no idling on either side
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == RANDOM_ITEMS - QUIET_ITEMS)
        quiet = 1'b1;
      maybe_idle_input();
      offer_number(random_number(), 1'b0, 1'b0);
    end
    in_valid <= 1'b0;

    // drain with a limit, then settle
    n = 0;
    while (answers_due.size() != 0 && n < DRAIN_LIMIT) begin
      @(posedge clk);
      n++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (answers_due.size() != 0)
      report_mismatch($sformatf("%0d transactions never produced a result",
                                answers_due.size()));

    $display("covered %0d directed, %0d held-off and %0d random numbers",
             directed.size(), HOLD_ITEMS, RANDOM_ITEMS);
    $display("%0d of %0d results checked were prime, %0d mismatches",
             primes_seen, results_seen, mismatch_count);
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

FILE: trial_division_prime_test_unit.f
rtl/core/tdp_pkg.sv
rtl/core/tdp_rem.sv
rtl/core/tdp_cand.sv
rtl/core/trial_division_prime_test_unit.sv
verif/testbench.sv
